[src/arcm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arcm_pkg
// Shared constants, types and helpers of the audio ring consumer mixer.
// ----------------------------------------------------------------------------
package arcm_pkg;

  localparam int RING_DEPTH    = 1024;
  localparam int ADDR_W        = $clog2(RING_DEPTH);
  localparam int PERIOD_LEN    = 64;
  localparam int FIP_W         = (PERIOD_LEN > 1) ? $clog2(PERIOD_LEN) : 1;
  localparam int SAMPLE_BITS   = 24;
  localparam int MAG_W         = SAMPLE_BITS - 1;
  localparam int BUS_W         = 28;
  localparam int GAIN_W        = 17;
  localparam int IDX_W         = 32;
  localparam int CNT_W         = 32;
  localparam int PEAK_W        = 31;
  localparam int GAIN_SHIFT    = SAMPLE_BITS - 10;
  localparam int PROD_W        = SAMPLE_BITS + GAIN_W + 1;
  localparam int GAINED_W      = PROD_W - GAIN_SHIFT;
  localparam int SUM_W         = BUS_W + 1;
  localparam int PEAK_K        = SAMPLE_BITS - 1 + 14;
  localparam int T_W           = MAG_W + GAIN_W;
  localparam int SCALE_W       = T_W + PEAK_W;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = GAIN_W;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [BUS_W-1:0]       bus_t;
  typedef logic [GAIN_W-1:0]             gain_t;
  typedef logic [MAG_W-1:0]              mag_t;
  typedef logic [CNT_W-1:0]              cnt_t;
  typedef logic [PEAK_W-1:0]             peak_t;
  typedef logic [CFG_IDX_W-1:0]          cfg_idx_t;

  localparam cfg_idx_t REG_GAIN   = 1'b0;
  localparam cfg_idx_t REG_SOURCE = 1'b1;

  localparam logic ACTION_PUSH = 1'b0;
  localparam logic ACTION_MIX  = 1'b1;

  localparam gain_t UNITY_GAIN = GAIN_W'(16384);
  localparam gain_t GAIN_LIMIT = GAIN_W'(65536);
  localparam mag_t  MAG_MAX    = '1;
  localparam peak_t PEAK_FULL  = '1;
  localparam bus_t  BUS_MAX    = {1'b0, {(BUS_W-1){1'b1}}};
  localparam bus_t  BUS_MIN    = {1'b1, {(BUS_W-1){1'b0}}};

  typedef struct packed {
    sample_t left;
    sample_t right;
  } frame_t;

  typedef struct packed {
    logic               we;
    logic               re;
    logic [ADDR_W-1:0]  addr;
  } ram_ctl_t;

  typedef struct packed {
    logic mix;
    logic played;
    logic start;
    logic last;
    bus_t bus_left;
    bus_t bus_right;
    cnt_t underrun;
  } mix_item_t;

  typedef struct packed {
    bus_t  bus_left;
    bus_t  bus_right;
    logic  played;
    logic  last;
    peak_t peak;
    cnt_t  underrun;
  } result_t;

  function automatic mag_t magnitude(sample_t s);
    logic [SAMPLE_BITS-1:0] a;
    a = s[SAMPLE_BITS-1] ? $unsigned(-s) : $unsigned(s);
    return a[SAMPLE_BITS-1] ? MAG_MAX : a[MAG_W-1:0];
  endfunction

endpackage

[src/arcm_item_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arcm_item_if
// Input channel: push or mix transaction with valid/ready handshake.
// ----------------------------------------------------------------------------
interface arcm_item_if;
  import arcm_pkg::*;

  logic    valid;
  logic    ready;
  logic    action;
  sample_t push_left;
  sample_t push_right;
  bus_t    bus_left_in;
  bus_t    bus_right_in;

  modport source (
    output valid, action, push_left, push_right, bus_left_in, bus_right_in,
    input  ready
  );

  modport sink (
    input  valid, action, push_left, push_right, bus_left_in, bus_right_in,
    output ready
  );
endinterface

[src/arcm_result_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arcm_result_if
// Output channel: mixed bus frame and meter status with valid/ready handshake.
// ----------------------------------------------------------------------------
interface arcm_result_if;
  import arcm_pkg::*;

  logic  valid;
  logic  ready;
  bus_t  bus_left_out;
  bus_t  bus_right_out;
  logic  played;
  logic  period_last;
  peak_t peak_level;
  cnt_t  underrun_total;

  modport source (
    output valid, bus_left_out, bus_right_out, played, period_last, peak_level,
           underrun_total,
    input  ready
  );

  modport sink (
    input  valid, bus_left_out, bus_right_out, played, period_last, peak_level,
           underrun_total,
    output ready
  );
endinterface

[src/arcm_ring_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arcm_ring_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module arcm_ring_ram #(
  parameter int DEPTH  = 1024,
  parameter int WIDTH  = 48,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic              re,
  input  logic [ADDR_W-1:0] addr,
  input  logic [WIDTH-1:0]  wdata,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

[src/arcm_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arcm_ctrl
// Ring indices, period decision, underrun count and configuration registers.
// ----------------------------------------------------------------------------
module arcm_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       accept,
  input  logic                       advance,
  input  logic                       action,
  input  arcm_pkg::sample_t          push_left,
  input  arcm_pkg::sample_t          push_right,
  input  arcm_pkg::bus_t             bus_left_in,
  input  arcm_pkg::bus_t             bus_right_in,
  input  logic                       wr_en,
  input  arcm_pkg::cfg_idx_t         wr_index,
  input  logic [arcm_pkg::CFG_DATA_W-1:0] wr_data,
  output arcm_pkg::ram_ctl_t         ram_ctl,
  output arcm_pkg::frame_t           ram_wdata,
  output arcm_pkg::gain_t            gain,
  output logic                       s1_valid,
  output arcm_pkg::mix_item_t        s1_item
);
  import arcm_pkg::*;

  logic [IDX_W-1:0] write_index;
  logic [IDX_W-1:0] read_index;
  logic [FIP_W-1:0] frame_in_period;
  logic             period_playing;
  cnt_t             underrun_count;
  logic             source_present;

  logic [IDX_W-1:0] pending;
  logic [IDX_W-1:0] rd_base;
  logic             short_data;
  logic             deep_data;
  logic             start;
  logic             go;
  logic             play;
  logic             last;
  logic             is_mix;
  cnt_t             underrun_next;

  always_comb begin
    is_mix     = (action == ACTION_MIX);
    pending    = write_index - read_index;
    short_data = pending[IDX_W-1] || (pending < IDX_W'(PERIOD_LEN));
    deep_data  = pending > IDX_W'(RING_DEPTH / 2);
    start      = (frame_in_period == '0);
    go         = start && source_present && !short_data;
    play       = start ? go : period_playing;
    rd_base    = (go && deep_data) ? write_index - IDX_W'(PERIOD_LEN) : read_index;
    last       = (frame_in_period == FIP_W'(PERIOD_LEN - 1));
    underrun_next = underrun_count +
                    CNT_W'(start && source_present && short_data);

    ram_ctl.we   = accept && !is_mix;
    ram_ctl.re   = accept && is_mix && play;
    ram_ctl.addr = is_mix ? rd_base[ADDR_W-1:0] : write_index[ADDR_W-1:0];
    ram_wdata.left  = push_left;
    ram_wdata.right = push_right;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_index     <= '0;
      read_index      <= '0;
      frame_in_period <= '0;
      period_playing  <= 1'b0;
      underrun_count  <= '0;
      gain            <= UNITY_GAIN;
      source_present  <= 1'b0;
    end else begin
      if (wr_en) begin
        unique case (wr_index)
          REG_GAIN: begin
            if (wr_data <= GAIN_LIMIT) begin
              gain <= wr_data;
            end
          end
          REG_SOURCE: begin
            if (wr_data[0] && !source_present) begin
              read_index <= write_index;
            end
            source_present <= wr_data[0];
          end
          default: ;
        endcase
      end
      if (accept) begin
        if (!is_mix) begin
          write_index <= write_index + IDX_W'(1);
        end else begin
          if (play) begin
            read_index <= rd_base + IDX_W'(1);
          end
          underrun_count  <= underrun_next;
          frame_in_period <= last ? '0 : frame_in_period + FIP_W'(1);
          period_playing  <= last ? 1'b0 : play;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_item.mix       <= is_mix;
      s1_item.played    <= is_mix && play;
      s1_item.start     <= is_mix && go;
      s1_item.last      <= is_mix && last;
      s1_item.bus_left  <= bus_left_in;
      s1_item.bus_right <= bus_right_in;
      s1_item.underrun  <= is_mix ? underrun_next : underrun_count;
    end
  end

endmodule

[src/arcm_mix.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arcm_mix
// Gain, bus mix with saturation, running peak and peak publish pipeline.
// ----------------------------------------------------------------------------
module arcm_mix (
  input  logic                clk,
  input  logic                rst,
  input  logic                s1_valid,
  input  arcm_pkg::mix_item_t s1_item,
  input  arcm_pkg::frame_t    rdata,
  input  arcm_pkg::gain_t     gain,
  input  logic                result_ready,
  output logic                advance,
  output logic                result_valid,
  output arcm_pkg::result_t   result
);
  import arcm_pkg::*;

  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (GAIN_SHIFT - 1);

  mag_t                     running_peak;
  peak_t                    published_peak;

  logic                     s2_valid;
  mix_item_t                s2_item;
  logic signed [PROD_W-1:0] s2_prod_l;
  logic signed [PROD_W-1:0] s2_prod_r;
  mag_t                     s2_peak;

  logic                     s3_valid;
  mix_item_t                s3_item;
  logic [T_W-1:0]           s3_t;

  // stage 1 signals
  logic signed [GAIN_W:0]   gain_s;
  mag_t                     mag_l;
  mag_t                     mag_r;
  mag_t                     peak_base;
  mag_t                     peak_next;

  // stage 2 signals
  logic signed [PROD_W-1:0] rnd_l;
  logic signed [PROD_W-1:0] rnd_r;
  logic signed [PROD_W-1:0] shf_l;
  logic signed [PROD_W-1:0] shf_r;
  logic signed [SUM_W-1:0]  sum_l;
  logic signed [SUM_W-1:0]  sum_r;
  bus_t                     mixed_l;
  bus_t                     mixed_r;
  mix_item_t                s3_item_next;

  // stage 3 signals
  logic [SCALE_W-1:0]       scaled;
  peak_t                    peak_calc;
  logic                     publish;
  peak_t                    peak_out;

  assign advance = !result_valid || result_ready;

  always_comb begin
    gain_s    = {1'b0, gain};
    mag_l     = magnitude(rdata.left);
    mag_r     = magnitude(rdata.right);
    peak_base = s1_item.start ? '0 : running_peak;
    peak_next = peak_base;
    if (mag_l > peak_next) begin
      peak_next = mag_l;
    end
    if (mag_r > peak_next) begin
      peak_next = mag_r;
    end
  end

  always_comb begin
    rnd_l = s2_prod_l + ROUND_HALF;
    rnd_r = s2_prod_r + ROUND_HALF;
    shf_l = rnd_l >>> GAIN_SHIFT;
    shf_r = rnd_r >>> GAIN_SHIFT;
    sum_l = SUM_W'(s2_item.bus_left) + SUM_W'($signed(shf_l[GAINED_W-1:0]));
    sum_r = SUM_W'(s2_item.bus_right) + SUM_W'($signed(shf_r[GAINED_W-1:0]));
    if (sum_l[SUM_W-1] != sum_l[SUM_W-2]) begin
      mixed_l = sum_l[SUM_W-1] ? BUS_MIN : BUS_MAX;
    end else begin
      mixed_l = sum_l[BUS_W-1:0];
    end
    if (sum_r[SUM_W-1] != sum_r[SUM_W-2]) begin
      mixed_r = sum_r[SUM_W-1] ? BUS_MIN : BUS_MAX;
    end else begin
      mixed_r = sum_r[BUS_W-1:0];
    end
    s3_item_next = s2_item;
    if (!s2_item.mix) begin
      s3_item_next.bus_left  = '0;
      s3_item_next.bus_right = '0;
    end else if (s2_item.played) begin
      s3_item_next.bus_left  = mixed_l;
      s3_item_next.bus_right = mixed_r;
    end
  end

  always_comb begin
    scaled    = {s3_t, {PEAK_W{1'b0}}} - SCALE_W'(s3_t);
    peak_calc = (s3_t[T_W-1:PEAK_K] != '0) ? PEAK_FULL : PEAK_W'(scaled >> PEAK_K);
    publish   = s3_item.mix && s3_item.played && s3_item.last;
    peak_out  = publish ? peak_calc : published_peak;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid       <= 1'b0;
      s3_valid       <= 1'b0;
      result_valid   <= 1'b0;
      running_peak   <= '0;
      published_peak <= '0;
    end else if (advance) begin
      s2_valid     <= s1_valid;
      s3_valid     <= s2_valid;
      result_valid <= s3_valid;
      if (s1_valid && s1_item.played) begin
        running_peak <= peak_next;
      end
      if (s3_valid && publish) begin
        published_peak <= peak_calc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_item   <= s1_item;
      s2_prod_l <= rdata.left * gain_s;
      s2_prod_r <= rdata.right * gain_s;
      s2_peak   <= peak_next;

      s3_item <= s3_item_next;
      s3_t    <= s2_peak * gain;

      result.bus_left  <= s3_item.bus_left;
      result.bus_right <= s3_item.bus_right;
      result.played    <= s3_item.played;
      result.last      <= s3_item.last;
      result.peak      <= peak_out;
      result.underrun  <= s3_item.underrun;
    end
  end

endmodule

[src/audio_ring_consumer_mixer_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_ring_consumer_mixer_top
// Stereo ring buffer consumer that mixes gained ring frames into two buses.
// An accepted transaction passes the s1, s2, s3 and result registers in turn.
// Throughput: one transaction per cycle, set by the single-port ring RAM.
// A stalled result holds the whole pipeline; ready follows it.
// Reset (rst, synchronous): clears indices, counters and meter, gain to unity.
// Ring contents are not cleared; there is no clearing pass.
// ----------------------------------------------------------------------------
module audio_ring_consumer_mixer_top (
  input  logic                            clk,
  input  logic                            rst,
  arcm_item_if.sink                       item,
  arcm_result_if.source                   result,
  input  logic                            wr_en,
  input  arcm_pkg::cfg_idx_t              wr_index,
  input  logic [arcm_pkg::CFG_DATA_W-1:0] wr_data
);
  import arcm_pkg::*;

  logic                      advance;
  logic                      accept;
  ram_ctl_t                  ram_ctl;
  frame_t                    ram_wdata;
  logic [$bits(frame_t)-1:0] ram_rdata;
  gain_t                     gain;
  logic                      s1_valid;
  mix_item_t                 s1_item;
  result_t                   res;

  assign item.ready = advance;
  assign accept     = item.valid && advance;

  arcm_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .advance      (advance),
    .action       (item.action),
    .push_left    (item.push_left),
    .push_right   (item.push_right),
    .bus_left_in  (item.bus_left_in),
    .bus_right_in (item.bus_right_in),
    .wr_en        (wr_en),
    .wr_index     (wr_index),
    .wr_data      (wr_data),
    .ram_ctl      (ram_ctl),
    .ram_wdata    (ram_wdata),
    .gain         (gain),
    .s1_valid     (s1_valid),
    .s1_item      (s1_item)
  );

  arcm_ring_ram #(
    .DEPTH (RING_DEPTH),
    .WIDTH ($bits(frame_t))
  ) u_ring_ram (
    .clk   (clk),
    .we    (ram_ctl.we),
    .re    (ram_ctl.re),
    .addr  (ram_ctl.addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  arcm_mix u_mix (
    .clk          (clk),
    .rst          (rst),
    .s1_valid     (s1_valid),
    .s1_item      (s1_item),
    .rdata        (frame_t'(ram_rdata)),
    .gain         (gain),
    .result_ready (result.ready),
    .advance      (advance),
    .result_valid (result.valid),
    .result       (res)
  );

  assign result.bus_left_out   = res.bus_left;
  assign result.bus_right_out  = res.bus_right;
  assign result.played         = res.played;
  assign result.period_last    = res.last;
  assign result.peak_level     = res.peak;
  assign result.underrun_total = res.underrun;

endmodule
